// File: design/brapq_pkg.sv
// shared constants, codes and controller/datapath interface types
package brapq_pkg;

   // array geometry
   localparam int NUM_ELEMENTS = 65536;
   localparam int BLOCK_SIZE   = 256;
   localparam int NUM_BLOCKS   = (NUM_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int BLK_DEPTH    = (NUM_BLOCKS > 1) ? NUM_BLOCKS : 2;

   // field and address widths
   localparam int CMD_W  = 2;
   localparam int IDX_W  = 16;
   localparam int VAL_W  = 32;
   localparam int WIDE_W = 32;
   localparam int EA_W   = $clog2(NUM_ELEMENTS);
   localparam int BS_W   = $clog2(BLOCK_SIZE);
   localparam int BA_W   = $clog2(BLK_DEPTH);

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SWEEP,
      ST_QSUM
   } state_type;

   // sweep phases of a range add
   typedef enum logic [1:0] {
      PH_SINGLE,
      PH_INNER,
      PH_LEFT,
      PH_RIGHT
   } phase_type;

   // controller to datapath commands
   typedef struct packed {
      logic      capture;
      logic      start;
      phase_type phase;
      logic      step;
      logic      load_wr;
      logic      query_rd;
      logic      query_out;
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             add_empty;
      logic             same_block;
      logic             has_inner;
      logic             sweep_last;
      logic             out_free;
   } sts_type;

endpackage

// File: design/brapq_ram.sv
// generic simple dual-port ram with registered read
module brapq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/brapq_ctrl.sv
// controller state machine: decode, sweep sequencing and result handoff
module brapq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  brapq_pkg::sts_type  sts,
   output brapq_pkg::ctl_type  ctl
);

   brapq_pkg::state_type state_ff, state_in;
   brapq_pkg::phase_type phase_ff, phase_in;

   // state and phase registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brapq_pkg::ST_IDLE;
         phase_ff <= brapq_pkg::PH_SINGLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      ctl           = '0;
      ctl.phase     = brapq_pkg::PH_SINGLE;
      req_stall     = 1'b1;
      unique case (state_ff)
         brapq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = brapq_pkg::ST_DECODE;
            end
         end
         brapq_pkg::ST_DECODE: begin
            state_in = brapq_pkg::ST_IDLE;
            unique case (sts.cmd)
               brapq_pkg::CMD_LOAD: begin
                  ctl.load_wr = 1'b1;
               end
               brapq_pkg::CMD_QUERY: begin
                  ctl.query_rd = 1'b1;
                  state_in     = brapq_pkg::ST_QSUM;
               end
               brapq_pkg::CMD_ADD: begin
                  if (!sts.add_empty) begin
                     ctl.start = 1'b1;
                     state_in  = brapq_pkg::ST_SWEEP;
                     if (sts.same_block) begin
                        ctl.phase = brapq_pkg::PH_SINGLE;
                     end else if (sts.has_inner) begin
                        ctl.phase = brapq_pkg::PH_INNER;
                     end else begin
                        ctl.phase = brapq_pkg::PH_LEFT;
                     end
                     phase_in = ctl.phase;
                  end
               end
               default: begin
                  state_in = brapq_pkg::ST_IDLE;
               end
            endcase
         end
         brapq_pkg::ST_SWEEP: begin
            // one element or mark per cycle, next phase chained on the last one
            ctl.step = 1'b1;
            if (sts.sweep_last) begin
               unique case (phase_ff)
                  brapq_pkg::PH_INNER: begin
                     ctl.start = 1'b1;
                     ctl.phase = brapq_pkg::PH_LEFT;
                     phase_in  = brapq_pkg::PH_LEFT;
                  end
                  brapq_pkg::PH_LEFT: begin
                     ctl.start = 1'b1;
                     ctl.phase = brapq_pkg::PH_RIGHT;
                     phase_in  = brapq_pkg::PH_RIGHT;
                  end
                  default: begin
                     state_in = brapq_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         brapq_pkg::ST_QSUM: begin
            if (sts.out_free) begin
               ctl.query_out = 1'b1;
               state_in      = brapq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brapq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/brapq_dpath.sv
// datapath: request registers, sweep address counter, element and mark memories
module brapq_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [brapq_pkg::CMD_W-1:0]      req_command,
   input  logic [brapq_pkg::IDX_W-1:0]      req_left_index,
   input  logic [brapq_pkg::IDX_W-1:0]      req_right_index,
   input  logic signed [brapq_pkg::VAL_W-1:0] req_operand_value,
   output logic                             rsp_valid,
   output logic signed [brapq_pkg::VAL_W-1:0] rsp_query_value,
   input  logic                             rsp_stall,
   input  brapq_pkg::ctl_type               ctl,
   output brapq_pkg::sts_type               sts
);

   localparam int PAD_W = brapq_pkg::WIDE_W - brapq_pkg::IDX_W;

   // captured request
   logic [brapq_pkg::CMD_W-1:0] cmd_ff;
   logic [brapq_pkg::IDX_W-1:0] lo_ff;
   logic [brapq_pkg::IDX_W-1:0] hi_ff;
   logic [brapq_pkg::VAL_W-1:0] amt_ff;

   // sweep counter and write-back stage
   logic [brapq_pkg::EA_W-1:0] addr_ff, addr_in;
   logic [brapq_pkg::EA_W-1:0] end_ff, end_in;
   logic                       sel_ff, sel_in;
   logic                       p_valid_ff;
   logic [brapq_pkg::EA_W-1:0] p_addr_ff;
   logic                       p_sel_ff;

   // mark valid bits and result register
   logic [brapq_pkg::BLK_DEPTH-1:0] bvalid_ff;
   logic                            rsp_valid_ff;
   logic [brapq_pkg::VAL_W-1:0]     rsp_value_ff;

   // index arithmetic
   logic [brapq_pkg::WIDE_W-1:0] lo_w, hi_w, hi_c_w, lb_w, hb_w;
   logic [brapq_pkg::WIDE_W-1:0] first_w, last_w;
   logic                         lo_ok, hi_ok;

   // memory ports
   logic                         e_wr_en, e_rd_en, b_wr_en, b_rd_en;
   logic [brapq_pkg::EA_W-1:0]   e_wr_addr, e_rd_addr;
   logic [brapq_pkg::BA_W-1:0]   b_wr_addr, b_rd_addr, p_blk, q_blk;
   logic [brapq_pkg::VAL_W-1:0]  e_wr_data, e_rd_data, b_wr_data, b_rd_data;
   logic [brapq_pkg::VAL_W-1:0]  p_mark, q_mark, q_sum;

   // request capture
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= req_command;
         lo_ff  <= req_left_index;
         hi_ff  <= req_right_index;
         amt_ff <= req_operand_value;
      end
   end

   // bounds, clamp and block numbers
   always_comb begin
      lo_w   = {{PAD_W{1'b0}}, lo_ff};
      hi_w   = {{PAD_W{1'b0}}, hi_ff};
      lo_ok  = lo_w < brapq_pkg::WIDE_W'(brapq_pkg::NUM_ELEMENTS);
      hi_ok  = hi_w < brapq_pkg::WIDE_W'(brapq_pkg::NUM_ELEMENTS);
      hi_c_w = hi_ok ? hi_w : brapq_pkg::WIDE_W'(brapq_pkg::NUM_ELEMENTS - 1);
      lb_w   = lo_w >> brapq_pkg::BS_W;
      hb_w   = hi_c_w >> brapq_pkg::BS_W;
   end

   // sweep bounds of the phase being started
   always_comb begin
      first_w = lo_w;
      last_w  = hi_c_w;
      unique case (ctl.phase)
         brapq_pkg::PH_SINGLE: begin
            first_w = lo_w;
            last_w  = hi_c_w;
         end
         brapq_pkg::PH_INNER: begin
            first_w = lb_w + 1'b1;
            last_w  = hb_w - 1'b1;
         end
         brapq_pkg::PH_LEFT: begin
            first_w = lo_w;
            last_w  = ((lb_w + 1'b1) << brapq_pkg::BS_W) - 1'b1;
         end
         brapq_pkg::PH_RIGHT: begin
            first_w = hb_w << brapq_pkg::BS_W;
            last_w  = hi_c_w;
         end
         default: begin
            first_w = lo_w;
            last_w  = hi_c_w;
         end
      endcase
   end

   // status to controller
   always_comb begin
      sts.cmd        = cmd_ff;
      sts.add_empty  = (lo_w > hi_w) || !lo_ok;
      sts.same_block = lb_w == hb_w;
      sts.has_inner  = hb_w > (lb_w + 1'b1);
      sts.sweep_last = addr_ff == end_ff;
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // sweep address counter
   always_comb begin
      addr_in = addr_ff;
      end_in  = end_ff;
      sel_in  = sel_ff;
      if (ctl.start) begin
         addr_in = first_w[brapq_pkg::EA_W-1:0];
         end_in  = last_w[brapq_pkg::EA_W-1:0];
         sel_in  = ctl.phase == brapq_pkg::PH_INNER;
      end else if (ctl.step) begin
         addr_in = addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      end_ff    <= end_in;
      sel_ff    <= sel_in;
      p_addr_ff <= addr_ff;
      p_sel_ff  <= sel_ff;
   end

   // write-back stage valid and mark valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         bvalid_ff  <= '0;
      end else begin
         p_valid_ff <= ctl.step;
         if (b_wr_en) begin
            bvalid_ff[b_wr_addr] <= 1'b1;
         end
      end
   end

   // element memory access: load, sweep read-modify-write, query read
   always_comb begin
      p_blk     = p_addr_ff[brapq_pkg::BA_W-1:0];
      q_blk     = hb_w[brapq_pkg::BA_W-1:0];
      p_mark    = bvalid_ff[p_blk] ? b_rd_data : '0;
      q_mark    = bvalid_ff[q_blk] ? b_rd_data : '0;

      e_rd_en   = ctl.query_rd || (ctl.step && !sel_ff);
      e_rd_addr = ctl.query_rd ? hi_c_w[brapq_pkg::EA_W-1:0] : addr_ff;
      e_wr_en   = (ctl.load_wr && lo_ok) || (p_valid_ff && !p_sel_ff);
      e_wr_addr = ctl.load_wr ? lo_w[brapq_pkg::EA_W-1:0] : p_addr_ff;
      e_wr_data = ctl.load_wr ? amt_ff : e_rd_data + amt_ff;

      b_rd_en   = ctl.query_rd || (ctl.step && sel_ff);
      b_rd_addr = ctl.query_rd ? q_blk : addr_ff[brapq_pkg::BA_W-1:0];
      b_wr_en   = p_valid_ff && p_sel_ff;
      b_wr_addr = p_blk;
      b_wr_data = p_mark + amt_ff;

      q_sum     = hi_ok ? e_rd_data + q_mark : '0;
   end

   brapq_ram #(
      .WIDTH (brapq_pkg::VAL_W),
      .DEPTH (brapq_pkg::NUM_ELEMENTS)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (e_wr_data),
      .rd_en   (e_rd_en),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd_data)
   );

   brapq_ram #(
      .WIDTH (brapq_pkg::VAL_W),
      .DEPTH (brapq_pkg::BLK_DEPTH)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // result register, held until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.query_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.query_out) begin
         rsp_value_ff <= q_sum;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_query_value = rsp_value_ff;

endmodule

// File: design/block_range_add_point_query.sv
// load: captured, then written in decode; point query: captured, read in decode, and the
// sum registered once the result register is free; range add: captured, decoded, then n
// edge elements and inner block marks swept one per cycle in the read-modify-write stage
// throughput: one item at a time, the next item is taken once the current one is done
// reset: synchronous, clears the controller, the result valid and all block marks at once;
// element memory is not cleared and holds no defined value until loaded
// top level: range add with point query over fixed blocks
module block_range_add_point_query (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [brapq_pkg::CMD_W-1:0]        req_command,
   input  logic [brapq_pkg::IDX_W-1:0]        req_left_index,
   input  logic [brapq_pkg::IDX_W-1:0]        req_right_index,
   input  logic signed [brapq_pkg::VAL_W-1:0] req_operand_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [brapq_pkg::VAL_W-1:0] rsp_query_value
);

   brapq_pkg::ctl_type ctl;
   brapq_pkg::sts_type sts;

   // sequencing
   brapq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // storage and arithmetic
   brapq_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_left_index    (req_left_index),
      .req_right_index   (req_right_index),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_query_value   (rsp_query_value),
      .rsp_stall         (rsp_stall),
      .ctl               (ctl),
      .sts               (sts)
   );

endmodule

// File: design/brapq_checker.sv
// port-level checker for the range add point query block, bound to the top level
module brapq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [brapq_pkg::CMD_W-1:0]        req_command,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [brapq_pkg::VAL_W-1:0] rsp_query_value
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_query_value))
      else $error("result changed while stalled");

   // an accepted item stalls the input in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in progress");

   // a new result only comes out of a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

   // loads, range adds and unused commands never produce a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command != brapq_pkg::CMD_QUERY)
      |-> ##2 !$rose(rsp_valid))
      else $error("result produced by a non-query item");

endmodule

bind block_range_add_point_query brapq_checker u_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the blocked range add and point query unit
module tb_top;

   localparam int NUM_ELEMENTS = brapq_pkg::NUM_ELEMENTS;
   localparam int BLOCK_SIZE   = brapq_pkg::BLOCK_SIZE;
   localparam int NUM_BLOCKS   = brapq_pkg::NUM_BLOCKS;
   localparam int CMD_W        = brapq_pkg::CMD_W;
   localparam int IDX_W        = brapq_pkg::IDX_W;
   localparam int VAL_W        = brapq_pkg::VAL_W;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int TARGET_ITEMS   = 780;
   localparam int IDLE_PCT       = 31;
   localparam int QUIET_FIRST    = 300;
   localparam int QUIET_LAST     = 420;
   localparam int DRAIN_CYCLES   = 800;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int REPORT_MAX     = 10;

   typedef struct {
      logic [CMD_W-1:0] command;
      logic [IDX_W-1:0] left_index;
      logic [IDX_W-1:0] right_index;
      logic [VAL_W-1:0] operand_value;
   } op_item_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_command = '0;
   logic [IDX_W-1:0]        req_left_index = '0;
   logic [IDX_W-1:0]        req_right_index = '0;
   logic signed [VAL_W-1:0] req_operand_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [VAL_W-1:0] rsp_query_value;

   op_item_type      pending_ops[$];
   logic [VAL_W-1:0] expected_sums[$];
   int               accepted_ops = 0;
   int               scheduled_ops = 0;
   int               mismatch_count = 0;
   int               idle_cycles = 0;

   // shadow of the element array and the per-block pending marks
   logic [VAL_W-1:0] elem_shadow [NUM_ELEMENTS];
   logic [VAL_W-1:0] mark_shadow [NUM_BLOCKS];

   // elements written so far, so that no unwritten element is ever read
   bit loaded [NUM_ELEMENTS];
   int loaded_list[$];

   wire quiet_phase = (accepted_ops >= QUIET_FIRST) && (accepted_ops < QUIET_LAST);

   block_range_add_point_query dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_left_index    (req_left_index),
      .req_right_index   (req_right_index),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_query_value   (rsp_query_value)
   );

   always #6 clock = ~clock;

   // apply one accepted command to the shadow state, queue the sum a query returns
   function automatic void predict_op(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] lo,
                                      logic [IDX_W-1:0] hi, logic [VAL_W-1:0] val);
      int first_idx, last_idx, lb, hb, i;
      logic [VAL_W-1:0] sum;
      case (cmd)
         brapq_pkg::CMD_LOAD: begin
            if (lo < NUM_ELEMENTS) elem_shadow[lo] = val;
         end
         brapq_pkg::CMD_ADD: begin
            first_idx = int'(lo);
            last_idx  = int'(hi);
            if (first_idx <= last_idx && first_idx < NUM_ELEMENTS) begin
               if (last_idx >= NUM_ELEMENTS) last_idx = NUM_ELEMENTS - 1;
               lb = first_idx / BLOCK_SIZE;
               hb = last_idx / BLOCK_SIZE;
               if (lb == hb) begin
                  for (i = first_idx; i <= last_idx; i++) elem_shadow[i] += val;
               end else begin
                  // inner blocks take the mark, edge blocks are swept per element
                  for (i = lb + 1; i < hb; i++) mark_shadow[i] += val;
                  for (i = first_idx; i < (lb + 1) * BLOCK_SIZE; i++)
                     elem_shadow[i] += val;
                  for (i = hb * BLOCK_SIZE; i <= last_idx; i++) elem_shadow[i] += val;
               end
            end
         end
         brapq_pkg::CMD_QUERY: begin
            sum = '0;
            if (hi < NUM_ELEMENTS) sum = elem_shadow[hi] + mark_shadow[hi / BLOCK_SIZE];
            expected_sums.push_back(sum);
         end
         default: ;
      endcase
   endfunction

   // operand with a bias toward the extremes
   function automatic logic [VAL_W-1:0] rand_word();
      case ($urandom_range(15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // queue one command and track which elements now hold a value
   function automatic void push_op(logic [CMD_W-1:0] cmd, int lo, int hi,
                                   logic [VAL_W-1:0] val);
      op_item_type op;
      op.command       = cmd;
      op.left_index    = IDX_W'(lo);
      op.right_index   = IDX_W'(hi);
      op.operand_value = val;
      pending_ops.push_back(op);
      if (cmd == brapq_pkg::CMD_LOAD && !loaded[op.left_index]) begin
         loaded[op.left_index] = 1'b1;
         loaded_list.push_back(int'(op.left_index));
      end
      if (cmd != CMD_UNUSED &&
          !(cmd == brapq_pkg::CMD_ADD && op.left_index > op.right_index))
         scheduled_ops++;
   endfunction

   function automatic void ensure_loaded(int idx);
      if (!loaded[idx]) push_op(brapq_pkg::CMD_LOAD, idx, $urandom, rand_word());
   endfunction

   function automatic int pick_loaded();
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   // input driver: predict each accepted transfer, then present the next one
   always @(posedge clock) begin : driver_proc
      op_item_type next_op;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_op(req_command, req_left_index, req_right_index, req_operand_value);
            accepted_ops <= accepted_ops + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_ops.size() > 0 &&
                (quiet_phase || $urandom_range(99) >= IDLE_PCT)) begin
               next_op = pending_ops.pop_front();
               req_valid         <= 1'b1;
               req_command       <= next_op.command;
               req_left_index    <= next_op.left_index;
               req_right_index   <= next_op.right_index;
               req_operand_value <= next_op.operand_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] want,
                                input logic [VAL_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("mismatch: %s, expected %h, actual %h", what, want, got);
   endtask

   // result monitor: random stall, compare each transfer with the oldest sum
   always @(posedge clock) begin : monitor_proc
      logic [VAL_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet_phase && ($urandom_range(99) < IDLE_PCT);
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               flag_mismatch("result with no query waiting", 'x, rsp_query_value);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_query_value !== want)
                  flag_mismatch("query_value", want, rsp_query_value);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus, reset and end of run
   initial begin : stimulus_proc
      int pick, lo, hi, lb, hb, i;
      for (i = 0; i < NUM_ELEMENTS; i++) elem_shadow[i] = '0;
      for (i = 0; i < NUM_BLOCKS; i++) mark_shadow[i] = '0;

      // directed: extreme indices and values, wrap, widest inner sweep
      push_op(brapq_pkg::CMD_LOAD, 0, 16'hFFFF, 32'h7FFF_FFFF);
      push_op(brapq_pkg::CMD_LOAD, NUM_ELEMENTS - 1, 0, 32'h8000_0000);
      push_op(brapq_pkg::CMD_QUERY, 16'hFFFF, 0, '1);
      push_op(brapq_pkg::CMD_QUERY, 0, NUM_ELEMENTS - 1, '0);
      push_op(brapq_pkg::CMD_ADD, 0, 0, 32'd1);
      push_op(brapq_pkg::CMD_QUERY, 0, 0, '0);
      push_op(brapq_pkg::CMD_LOAD, BLOCK_SIZE - 1, 0, 32'd10);
      push_op(brapq_pkg::CMD_LOAD, NUM_ELEMENTS - BLOCK_SIZE, 0, 32'd20);
      push_op(brapq_pkg::CMD_ADD, BLOCK_SIZE - 1, NUM_ELEMENTS - BLOCK_SIZE, '1);
      push_op(brapq_pkg::CMD_QUERY, 0, BLOCK_SIZE - 1, '0);
      push_op(brapq_pkg::CMD_QUERY, 0, NUM_ELEMENTS - BLOCK_SIZE, '0);
      // load after marks: the block mark still applies on the read
      push_op(brapq_pkg::CMD_LOAD, 1000, 0, 32'd5);
      push_op(brapq_pkg::CMD_QUERY, 0, 1000, '0);
      push_op(brapq_pkg::CMD_ADD, NUM_ELEMENTS - 1, NUM_ELEMENTS - 1, 32'h7FFF_FFFF);
      push_op(brapq_pkg::CMD_QUERY, 0, NUM_ELEMENTS - 1, '0);
      // reversed range and the unused command change nothing
      push_op(brapq_pkg::CMD_ADD, NUM_ELEMENTS - 1, 0, 32'd3);
      push_op(CMD_UNUSED, 16'hFFFF, 16'hFFFF, '1);
      push_op(brapq_pkg::CMD_QUERY, 0, 0, '0);
      push_op(brapq_pkg::CMD_QUERY, 0, 1000, '0);

      // random: mostly range adds over loaded edges followed by reads
      while (scheduled_ops < TARGET_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            if ($urandom_range(2) == 0) begin
               lo = $urandom_range(NUM_ELEMENTS - 1);
               hi = lo + $urandom_range(7);
               if (hi / BLOCK_SIZE != lo / BLOCK_SIZE)
                  hi = (lo / BLOCK_SIZE) * BLOCK_SIZE + BLOCK_SIZE - 1;
               for (i = lo; i <= hi; i++) ensure_loaded(i);
            end else begin
               lb = $urandom_range(NUM_BLOCKS - 2);
               hb = $urandom_range(NUM_BLOCKS - 1, lb + 1);
               lo = (lb + 1) * BLOCK_SIZE - 1 - $urandom_range(7);
               hi = hb * BLOCK_SIZE + $urandom_range(7);
               for (i = lo; i < (lb + 1) * BLOCK_SIZE; i++) ensure_loaded(i);
               for (i = hb * BLOCK_SIZE; i <= hi; i++) ensure_loaded(i);
            end
            push_op(brapq_pkg::CMD_ADD, lo, hi, rand_word());
            push_op(brapq_pkg::CMD_QUERY, $urandom, lo, rand_word());
            push_op(brapq_pkg::CMD_QUERY, $urandom, hi, rand_word());
            if ($urandom_range(1) == 0)
               push_op(brapq_pkg::CMD_QUERY, $urandom, pick_loaded(), rand_word());
         end else if (pick < 70) begin
            push_op(brapq_pkg::CMD_LOAD, $urandom_range(NUM_ELEMENTS - 1), $urandom,
                    rand_word());
         end else if (pick < 90) begin
            push_op(brapq_pkg::CMD_QUERY, $urandom, pick_loaded(), rand_word());
         end else if (pick < 95) begin
            push_op(CMD_UNUSED, $urandom, $urandom, rand_word());
         end else begin
            lo = $urandom_range(NUM_ELEMENTS - 1, 1);
            push_op(brapq_pkg::CMD_ADD, lo, $urandom_range(lo - 1), rand_word());
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // drain: all commands taken, all sums returned, then the tail latency
      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
design/brapq_pkg.sv
design/brapq_ram.sv
design/brapq_ctrl.sv
design/brapq_dpath.sv
design/block_range_add_point_query.sv
design/brapq_checker.sv
tb/tb_top.sv
